@@ hw/rtl/smx_pkg.sv @@
package smx_pkg;

  localparam int DATA_DEPTH  = 64;
  localparam int FRAME_DEPTH = 64;
  localparam int MEM_WORDS   = 64;
  localparam int PROG_WORDS  = 1024;

  localparam int VAL_W  = 32;
  localparam int TAG_W  = 3;
  localparam int PC_W   = 10;
  localparam int FUNC_W = 5;
  localparam int FLT_W  = 3;

  localparam int DA_W = $clog2(DATA_DEPTH);
  localparam int DP_W = $clog2(DATA_DEPTH + 1);
  localparam int FA_W = $clog2(FRAME_DEPTH);
  localparam int FP_W = $clog2(FRAME_DEPTH + 1);
  localparam int MA_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  localparam logic [FUNC_W-1:0] OP_PUSH = 5'd0;
  localparam logic [FUNC_W-1:0] OP_POP  = 5'd1;
  localparam logic [FUNC_W-1:0] OP_DUP  = 5'd2;
  localparam logic [FUNC_W-1:0] OP_ADD  = 5'd3;
  localparam logic [FUNC_W-1:0] OP_SUB  = 5'd4;
  localparam logic [FUNC_W-1:0] OP_MUL  = 5'd5;
  localparam logic [FUNC_W-1:0] OP_DIV  = 5'd6;
  localparam logic [FUNC_W-1:0] OP_JMP  = 5'd7;
  localparam logic [FUNC_W-1:0] OP_JIT  = 5'd8;
  localparam logic [FUNC_W-1:0] OP_JIF  = 5'd9;
  localparam logic [FUNC_W-1:0] OP_CALL = 5'd10;
  localparam logic [FUNC_W-1:0] OP_RET  = 5'd11;
  localparam logic [FUNC_W-1:0] OP_EQ   = 5'd12;
  localparam logic [FUNC_W-1:0] OP_GT   = 5'd13;
  localparam logic [FUNC_W-1:0] OP_GE   = 5'd14;
  localparam logic [FUNC_W-1:0] OP_LT   = 5'd15;
  localparam logic [FUNC_W-1:0] OP_LE   = 5'd16;
  localparam logic [FUNC_W-1:0] OP_NE   = 5'd17;
  localparam logic [FUNC_W-1:0] OP_STO  = 5'd18;
  localparam logic [FUNC_W-1:0] OP_RCL  = 5'd19;
  localparam logic [FUNC_W-1:0] OP_END  = 5'd20;
  localparam logic [FUNC_W-1:0] OP_PRN  = 5'd21;
  localparam logic [FUNC_W-1:0] OP_STL  = 5'd22;
  localparam logic [FUNC_W-1:0] OP_RCE  = 5'd23;
  localparam logic [FUNC_W-1:0] OP_ALC  = 5'd24;
  localparam logic [FUNC_W-1:0] OP_FRE  = 5'd25;

  localparam logic [FLT_W-1:0] FLT_OK    = 3'd0;
  localparam logic [FLT_W-1:0] FLT_UNDER = 3'd1;
  localparam logic [FLT_W-1:0] FLT_OVER  = 3'd2;
  localparam logic [FLT_W-1:0] FLT_DIV0  = 3'd3;
  localparam logic [FLT_W-1:0] FLT_ADDR  = 3'd4;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [VAL_W-1:0] val;
  } cell_t;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic signed [VAL_W-1:0] arg_value;
    logic [TAG_W-1:0]        arg_tag;
  } cmd_t;

  typedef struct packed {
    logic [PC_W-1:0]         next_address;
    logic                    halted;
    logic                    print_valid;
    logic [TAG_W-1:0]        print_tag;
    logic signed [VAL_W-1:0] print_value;
    logic [FLT_W-1:0]        fault;
  } res_t;

endpackage

@@ hw/rtl/smx_div.sv @@
module smx_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [smx_pkg::VAL_W-1:0] dividend,
  input  logic signed [smx_pkg::VAL_W-1:0] divisor,
  output logic        [smx_pkg::VAL_W-1:0] quotient,
  output logic                             done
);

  localparam int CNT_W = $clog2(smx_pkg::VAL_W + 1);

  logic [CNT_W-1:0]          cnt;
  logic [smx_pkg::VAL_W-1:0] rem;
  logic [smx_pkg::VAL_W-1:0] quo;
  logic [smx_pkg::VAL_W-1:0] dvs;
  logic                      neg;
  logic [smx_pkg::VAL_W:0]   trial;

  assign trial = {rem, quo[smx_pkg::VAL_W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(smx_pkg::VAL_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[smx_pkg::VAL_W-1] ? (~dividend + 1'b1) : dividend;
      dvs <= divisor[smx_pkg::VAL_W-1] ? (~divisor + 1'b1) : divisor;
      neg <= dividend[smx_pkg::VAL_W-1] ^ divisor[smx_pkg::VAL_W-1];
    end else if (cnt != '0) begin
      if (!trial[smx_pkg::VAL_W]) begin
        rem <= trial[smx_pkg::VAL_W-1:0];
        quo <= {quo[smx_pkg::VAL_W-2:0], 1'b1};
      end else begin
        rem <= {rem[smx_pkg::VAL_W-2:0], quo[smx_pkg::VAL_W-1]};
        quo <= {quo[smx_pkg::VAL_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? (~quo + 1'b1) : quo;

endmodule

@@ hw/rtl/stack_machine_executor_top.sv @@
// Stack machine core: one instruction beat in, one result beat out. The data stack, frame
// stack and data memory are synchronous RAMs read when the instruction is accepted, so an
// instruction is accepted and read, then executed and written back; call adds a state
// because its two frame entries share the one frame stack write port, and div waits in its
// own state for the quotient from a radix-2 divider at one bit per cycle. A result that is
// not taken holds the core in its last cycle; the next instruction is accepted once the core
// is back in its idle state.
module stack_machine_executor_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  smx_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output smx_pkg::res_t res
);

  localparam int LW = smx_pkg::VAL_W + 2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_CALL = 4'b1000
  } state_t;

  state_t state, state_next;

  smx_pkg::cmd_t  cmd_q;
  smx_pkg::cell_t dstk [smx_pkg::DATA_DEPTH];
  smx_pkg::cell_t fstk [smx_pkg::FRAME_DEPTH];
  smx_pkg::cell_t dmem [smx_pkg::MEM_WORDS];
  smx_pkg::cell_t d_rd0, d_rd1, f_rd0, f_rd1, m_rd;

  logic [smx_pkg::DP_W-1:0] dtop, dtop_n;
  logic [smx_pkg::FP_W-1:0] ftop, ftop_n;
  logic [smx_pkg::FP_W-1:0] fbase, fbase_n;
  logic [smx_pkg::PC_W-1:0] pc, pc_n, nx, pc_inc;
  logic                     stopped, stop_n;

  logic                     cmd_fire, out_free, commit;
  logic [smx_pkg::DP_W-1:0] d_idx1, d_idx2;
  logic [smx_pkg::FP_W-1:0] f_idx1, f_idx2;
  logic signed [LW-1:0]     loc_in, loc_x, nt;
  logic                     loc_ok, tgt_ok, mem_ok, num, take;

  logic [smx_pkg::FLT_W-1:0] fault;
  logic                      pvalid;
  smx_pkg::cell_t            pcell;
  logic                      is_div, is_call;
  logic signed [smx_pkg::VAL_W-1:0] x, y;
  logic [smx_pkg::VAL_W-1:0] alu, div_q;
  logic                      div_done;
  logic [smx_pkg::VAL_W-1:0] rbase, rret;

  logic                     d_we_x, d_we, f_we_x, f_we, m_we;
  logic [smx_pkg::DA_W-1:0] d_wa;
  smx_pkg::cell_t           d_wd, f_wd, f_wd_x;
  logic [smx_pkg::FA_W-1:0] f_wa, f_wa_x;

  function automatic logic signed [LW-1:0] loc_of(logic signed [smx_pkg::VAL_W-1:0] a,
                                                   logic [smx_pkg::FP_W-1:0] b);
    return {{2{a[smx_pkg::VAL_W-1]}}, a} + $signed(LW'(b)) - LW'(1);
  endfunction

  assign cmd_ready = (state == ST_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign out_free  = !res_valid || res_ready;

  assign d_idx1 = dtop - smx_pkg::DP_W'(1);
  assign d_idx2 = dtop - smx_pkg::DP_W'(2);
  assign f_idx1 = ftop - smx_pkg::FP_W'(1);
  assign f_idx2 = ftop - smx_pkg::FP_W'(2);
  assign loc_in = loc_of(cmd.arg_value, fbase);
  assign loc_x  = loc_of(cmd_q.arg_value, fbase);

  // memories, read at accept, written back at commit (call writes its first frame entry in the execute state)
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      d_rd0 <= dstk[d_idx1[smx_pkg::DA_W-1:0]];
      d_rd1 <= dstk[d_idx2[smx_pkg::DA_W-1:0]];
    end
    if (d_we) begin
      dstk[d_wa] <= d_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      f_rd0 <= fstk[(cmd.func == smx_pkg::OP_RCE) ? loc_in[smx_pkg::FA_W-1:0]
                                                   : f_idx1[smx_pkg::FA_W-1:0]];
      f_rd1 <= fstk[f_idx2[smx_pkg::FA_W-1:0]];
    end
    if (f_we) begin
      fstk[f_wa] <= f_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      m_rd <= dmem[cmd.arg_value[smx_pkg::MA_W-1:0]];
    end
    if (m_we && commit) begin
      dmem[cmd_q.arg_value[smx_pkg::MA_W-1:0]] <= d_rd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      cmd_q <= cmd;
    end
  end

  assign x   = $signed(d_rd1.val);
  assign y   = $signed(d_rd0.val);
  assign num = (d_rd0.tag == '0) && (d_rd1.tag == '0);

  always_comb begin
    case (cmd_q.func)
      smx_pkg::OP_ADD: alu = x + y;
      smx_pkg::OP_SUB: alu = x - y;
      smx_pkg::OP_MUL: alu = x * y;
      smx_pkg::OP_DIV: alu = div_q;
      smx_pkg::OP_EQ:  alu = smx_pkg::VAL_W'(x == y);
      smx_pkg::OP_GT:  alu = smx_pkg::VAL_W'(x > y);
      smx_pkg::OP_GE:  alu = smx_pkg::VAL_W'(x >= y);
      smx_pkg::OP_LT:  alu = smx_pkg::VAL_W'(x < y);
      smx_pkg::OP_LE:  alu = smx_pkg::VAL_W'(x <= y);
      default:         alu = smx_pkg::VAL_W'(x != y);
    endcase
  end

  smx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_EXEC && is_div),
    .dividend (x),
    .divisor  (y),
    .quotient (div_q),
    .done     (div_done)
  );

  assign pc_inc = (pc == smx_pkg::PC_W'(smx_pkg::PROG_WORDS - 1)) ? '0 : pc + 1'b1;
  assign tgt_ok = !cmd_q.arg_value[smx_pkg::VAL_W-1] &&
                  (cmd_q.arg_value < smx_pkg::VAL_W'(smx_pkg::PROG_WORDS));
  assign mem_ok = !cmd_q.arg_value[smx_pkg::VAL_W-1] &&
                  (cmd_q.arg_value < smx_pkg::VAL_W'(smx_pkg::MEM_WORDS));
  assign loc_ok = !loc_x[LW-1] && (loc_x < LW'(smx_pkg::FRAME_DEPTH));
  assign take   = (d_rd0.val != '0) == (cmd_q.func == smx_pkg::OP_JIT);
  assign rbase  = f_rd0.val;
  assign rret   = f_rd1.val;
  assign nt     = (cmd_q.func == smx_pkg::OP_ALC)
                ? $signed(LW'(ftop)) + {{2{cmd_q.arg_value[smx_pkg::VAL_W-1]}}, cmd_q.arg_value}
                : $signed(LW'(ftop)) - {{2{cmd_q.arg_value[smx_pkg::VAL_W-1]}}, cmd_q.arg_value};

  always_comb begin
    fault   = smx_pkg::FLT_OK;
    nx      = pc_inc;
    dtop_n  = dtop;
    ftop_n  = ftop;
    fbase_n = fbase;
    stop_n  = stopped;
    pvalid  = 1'b0;
    pcell   = '0;
    is_div  = 1'b0;
    is_call = 1'b0;
    d_we_x  = 1'b0;
    d_wa    = dtop[smx_pkg::DA_W-1:0];
    d_wd    = d_rd0;
    f_we_x  = 1'b0;
    f_wa_x  = loc_x[smx_pkg::FA_W-1:0];
    f_wd_x  = d_rd0;
    m_we    = 1'b0;
    if (stopped) begin
      nx = pc;
    end else begin
      unique case (cmd_q.func) inside
        smx_pkg::OP_PUSH: begin
          if (dtop >= smx_pkg::DP_W'(smx_pkg::DATA_DEPTH)) begin
            fault = smx_pkg::FLT_OVER;
          end else begin
            d_we_x = 1'b1;
            d_wd   = '{tag: cmd_q.arg_tag, val: cmd_q.arg_value};
            dtop_n = dtop + 1'b1;
          end
        end
        smx_pkg::OP_POP: begin
          if (dtop == '0) fault = smx_pkg::FLT_UNDER;
          else dtop_n = d_idx1;
        end
        smx_pkg::OP_DUP: begin
          if (dtop == '0) begin
            fault = smx_pkg::FLT_UNDER;
          end else if (dtop >= smx_pkg::DP_W'(smx_pkg::DATA_DEPTH)) begin
            fault = smx_pkg::FLT_OVER;
          end else begin
            d_we_x = 1'b1;
            dtop_n = dtop + 1'b1;
          end
        end
        smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_DIV,
        smx_pkg::OP_EQ, smx_pkg::OP_GT, smx_pkg::OP_GE, smx_pkg::OP_LT,
        smx_pkg::OP_LE, smx_pkg::OP_NE: begin
          if (dtop < smx_pkg::DP_W'(2)) begin
            fault = smx_pkg::FLT_UNDER;
          end else if (num && cmd_q.func == smx_pkg::OP_DIV && y == '0) begin
            fault = smx_pkg::FLT_DIV0;
          end else begin
            dtop_n = d_idx2;
            if (num) begin
              is_div = (cmd_q.func == smx_pkg::OP_DIV);
              d_we_x = 1'b1;
              d_wa   = d_idx2[smx_pkg::DA_W-1:0];
              d_wd   = '{tag: '0, val: alu};
              dtop_n = d_idx1;
            end
          end
        end
        smx_pkg::OP_JMP: begin
          if (!tgt_ok) fault = smx_pkg::FLT_ADDR;
          else nx = cmd_q.arg_value[smx_pkg::PC_W-1:0];
        end
        smx_pkg::OP_JIT, smx_pkg::OP_JIF: begin
          if (dtop == '0) begin
            fault = smx_pkg::FLT_UNDER;
          end else if (take && !tgt_ok) begin
            fault = smx_pkg::FLT_ADDR;
          end else begin
            dtop_n = d_idx1;
            if (take) nx = cmd_q.arg_value[smx_pkg::PC_W-1:0];
          end
        end
        smx_pkg::OP_CALL: begin
          if (!tgt_ok) begin
            fault = smx_pkg::FLT_ADDR;
          end else if (LW'(ftop) + LW'(2) > LW'(smx_pkg::FRAME_DEPTH)) begin
            fault = smx_pkg::FLT_OVER;
          end else begin
            is_call = 1'b1;
            ftop_n  = ftop + smx_pkg::FP_W'(2);
            fbase_n = ftop + smx_pkg::FP_W'(2);
            nx      = cmd_q.arg_value[smx_pkg::PC_W-1:0];
          end
        end
        smx_pkg::OP_RET: begin
          if (ftop < smx_pkg::FP_W'(2)) begin
            fault = smx_pkg::FLT_UNDER;
          end else if (rbase[smx_pkg::VAL_W-1] ||
                       rbase > smx_pkg::VAL_W'(smx_pkg::FRAME_DEPTH) ||
                       rret[smx_pkg::VAL_W-1] ||
                       rret >= smx_pkg::VAL_W'(smx_pkg::PROG_WORDS)) begin
            fault = smx_pkg::FLT_ADDR;
          end else begin
            ftop_n  = f_idx2;
            fbase_n = rbase[smx_pkg::FP_W-1:0];
            nx      = (rret[smx_pkg::PC_W-1:0] == smx_pkg::PC_W'(smx_pkg::PROG_WORDS - 1))
                    ? '0 : rret[smx_pkg::PC_W-1:0] + 1'b1;
          end
        end
        smx_pkg::OP_STO: begin
          if (!mem_ok) begin
            fault = smx_pkg::FLT_ADDR;
          end else if (dtop == '0) begin
            fault = smx_pkg::FLT_UNDER;
          end else begin
            m_we   = 1'b1;
            dtop_n = d_idx1;
          end
        end
        smx_pkg::OP_RCL: begin
          if (!mem_ok) begin
            fault = smx_pkg::FLT_ADDR;
          end else if (dtop >= smx_pkg::DP_W'(smx_pkg::DATA_DEPTH)) begin
            fault = smx_pkg::FLT_OVER;
          end else begin
            d_we_x = 1'b1;
            d_wd   = m_rd;
            dtop_n = dtop + 1'b1;
          end
        end
        smx_pkg::OP_END: begin
          stop_n = 1'b1;
          nx     = pc;
        end
        smx_pkg::OP_PRN: begin
          if (dtop == '0) begin
            fault = smx_pkg::FLT_UNDER;
          end else begin
            dtop_n = d_idx1;
            pvalid = 1'b1;
            pcell  = d_rd0;
          end
        end
        smx_pkg::OP_STL: begin
          if (!loc_ok) begin
            fault = smx_pkg::FLT_ADDR;
          end else if (dtop == '0) begin
            fault = smx_pkg::FLT_UNDER;
          end else begin
            f_we_x = 1'b1;
            dtop_n = d_idx1;
          end
        end
        smx_pkg::OP_RCE: begin
          if (!loc_ok) begin
            fault = smx_pkg::FLT_ADDR;
          end else if (dtop >= smx_pkg::DP_W'(smx_pkg::DATA_DEPTH)) begin
            fault = smx_pkg::FLT_OVER;
          end else begin
            d_we_x = 1'b1;
            d_wd   = f_rd0;
            dtop_n = dtop + 1'b1;
          end
        end
        smx_pkg::OP_ALC, smx_pkg::OP_FRE: begin
          if (nt[LW-1]) fault = smx_pkg::FLT_UNDER;
          else if (nt > LW'(smx_pkg::FRAME_DEPTH)) fault = smx_pkg::FLT_OVER;
          else ftop_n = nt[smx_pkg::FP_W-1:0];
        end
        default: begin
        end
      endcase
    end
    pc_n = (fault == smx_pkg::FLT_OK) ? nx : pc;
  end

  always_comb begin
    commit     = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_fire) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (is_div) begin
          state_next = ST_DIV;
        end else if (is_call) begin
          state_next = ST_CALL;
        end else if (out_free) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done && out_free) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_CALL: begin
        if (out_free) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // call saves the return address first, then the frame base
  always_comb begin
    f_we = f_we_x && commit;
    f_wa = f_wa_x;
    f_wd = f_wd_x;
    if (state == ST_EXEC && is_call) begin
      f_we = 1'b1;
      f_wa = ftop[smx_pkg::FA_W-1:0];
      f_wd = '{tag: '0, val: smx_pkg::VAL_W'(pc)};
    end else if (state == ST_CALL) begin
      f_we = commit;
      f_wa = ftop[smx_pkg::FA_W-1:0] + smx_pkg::FA_W'(1);
      f_wd = '{tag: '0, val: smx_pkg::VAL_W'(fbase)};
    end
  end

  assign d_we = d_we_x && commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      dtop    <= '0;
      ftop    <= '0;
      fbase   <= '0;
      pc      <= '0;
      stopped <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        pc      <= pc_n;
        stopped <= stop_n;
        if (fault == smx_pkg::FLT_OK) begin
          dtop  <= dtop_n;
          ftop  <= ftop_n;
          fbase <= fbase_n;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res.next_address <= pc_n;
      res.halted       <= stop_n;
      res.print_valid  <= pvalid;
      res.print_tag    <= pcell.tag;
      res.print_value  <= pcell.val;
      res.fault        <= fault;
    end
  end

  a_dtop_range: assert property (@(posedge clk) disable iff (rst)
    dtop <= smx_pkg::DP_W'(smx_pkg::DATA_DEPTH))
    else $error("data stack pointer past depth");

  a_ftop_range: assert property (@(posedge clk) disable iff (rst)
    ftop <= smx_pkg::FP_W'(smx_pkg::FRAME_DEPTH) && fbase <= smx_pkg::FP_W'(smx_pkg::FRAME_DEPTH))
    else $error("frame pointer past depth");

  a_fault_holds_pc: assert property (@(posedge clk) disable iff (rst)
    commit && fault != smx_pkg::FLT_OK |=> pc == $past(pc) && dtop == $past(dtop))
    else $error("faulting instruction changed state");

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped && pc == $past(pc))
    else $error("core left halted state");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC && is_div |=> state == ST_DIV && !div_done)
    else $error("divider not started");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  smx_pkg::cmd_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  smx_pkg::res_t res;

  always #4 clk = ~clk;

  stack_machine_executor_top uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  typedef struct {
    smx_pkg::cmd_t c;
    bit            typed;
    smx_pkg::res_t r;
  } step_t;

  // machine state mirror
  smx_pkg::cell_t dstk [smx_pkg::DATA_DEPTH];
  smx_pkg::cell_t fstk [smx_pkg::FRAME_DEPTH];
  smx_pkg::cell_t dmem [smx_pkg::MEM_WORDS];
  bit    fwr [smx_pkg::FRAME_DEPTH];
  bit    mwr [smx_pkg::MEM_WORDS];
  int    dtop, ftop, pc, fbase;
  bit    stopped;

  smx_pkg::res_t pending_results[$];
  step_t program_rows[$];
  int    mismatches;
  int    cyc;
  bit    held_off;
  bit    done_sending;

  function automatic smx_pkg::res_t mkres(int na, bit pv, logic [smx_pkg::TAG_W-1:0] pt,
                                          logic [smx_pkg::VAL_W-1:0] pval,
                                          logic [smx_pkg::FLT_W-1:0] flt);
    smx_pkg::res_t r;
    r.next_address = na[smx_pkg::PC_W-1:0];
    r.halted = 1'b0;
    r.print_valid = pv;
    r.print_tag = pt;
    r.print_value = pval;
    r.fault = flt;
    return r;
  endfunction

  function automatic smx_pkg::res_t execute(smx_pkg::cmd_t c);
    smx_pkg::res_t r;
    longint a, loc, x, y, q, nt, sb, sr;
    int nxt;
    logic [smx_pkg::FLT_W-1:0] flt;
    smx_pkg::cell_t ca, cb, cr;
    bit num, take, tgt_ok, mem_ok, loc_ok;
    a = c.arg_value;
    loc = a + fbase - 1;
    tgt_ok = a >= 0 && a < smx_pkg::PROG_WORDS;
    mem_ok = a >= 0 && a < smx_pkg::MEM_WORDS;
    loc_ok = loc >= 0 && loc < smx_pkg::FRAME_DEPTH;
    nxt = (pc + 1) % smx_pkg::PROG_WORDS;
    flt = smx_pkg::FLT_OK;
    r = '0;
    if (stopped) begin
      r.next_address = pc[smx_pkg::PC_W-1:0];
      r.halted = 1'b1;
      return r;
    end
    case (c.func)
      smx_pkg::OP_PUSH: begin
        if (dtop >= smx_pkg::DATA_DEPTH) flt = smx_pkg::FLT_OVER;
        else begin
          dstk[dtop] = '{c.arg_tag, c.arg_value};
          dtop++;
        end
      end
      smx_pkg::OP_POP: begin
        if (dtop < 1) flt = smx_pkg::FLT_UNDER;
        else dtop--;
      end
      smx_pkg::OP_DUP: begin
        if (dtop < 1) flt = smx_pkg::FLT_UNDER;
        else if (dtop >= smx_pkg::DATA_DEPTH) flt = smx_pkg::FLT_OVER;
        else begin
          dstk[dtop] = dstk[dtop-1];
          dtop++;
        end
      end
      smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_DIV,
      smx_pkg::OP_EQ, smx_pkg::OP_GT, smx_pkg::OP_GE, smx_pkg::OP_LT,
      smx_pkg::OP_LE, smx_pkg::OP_NE: begin
        if (dtop < 2) flt = smx_pkg::FLT_UNDER;
        else begin
          cb = dstk[dtop-1];
          ca = dstk[dtop-2];
          x = $signed(ca.val);
          y = $signed(cb.val);
          num = ca.tag == 0 && cb.tag == 0;
          if (num && c.func == smx_pkg::OP_DIV && y == 0) flt = smx_pkg::FLT_DIV0;
          else begin
            dtop -= 2;
            if (num) begin
              case (c.func)
                smx_pkg::OP_ADD: q = x + y;
                smx_pkg::OP_SUB: q = x - y;
                smx_pkg::OP_MUL: q = x * y;
                smx_pkg::OP_DIV: q = x / y;
                smx_pkg::OP_EQ:  q = x == y;
                smx_pkg::OP_GT:  q = x > y;
                smx_pkg::OP_GE:  q = x >= y;
                smx_pkg::OP_LT:  q = x < y;
                smx_pkg::OP_LE:  q = x <= y;
                default: q = x != y;
              endcase
              dstk[dtop] = '{'0, q[31:0]};
              dtop++;
            end
          end
        end
      end
      smx_pkg::OP_JMP: begin
        if (!tgt_ok) flt = smx_pkg::FLT_ADDR;
        else nxt = int'(a);
      end
      smx_pkg::OP_JIT, smx_pkg::OP_JIF: begin
        if (dtop < 1) flt = smx_pkg::FLT_UNDER;
        else begin
          take = (dstk[dtop-1].val != 0) == (c.func == smx_pkg::OP_JIT);
          if (take && !tgt_ok) flt = smx_pkg::FLT_ADDR;
          else begin
            dtop--;
            if (take) nxt = int'(a);
          end
        end
      end
      smx_pkg::OP_CALL: begin
        if (!tgt_ok) flt = smx_pkg::FLT_ADDR;
        else if (ftop + 2 > smx_pkg::FRAME_DEPTH) flt = smx_pkg::FLT_OVER;
        else begin
          fstk[ftop] = '{'0, 32'(pc)};
          fstk[ftop+1] = '{'0, 32'(fbase)};
          fwr[ftop] = 1;
          fwr[ftop+1] = 1;
          ftop += 2;
          fbase = ftop;
          nxt = int'(a);
        end
      end
      smx_pkg::OP_RET: begin
        if (ftop < 2) flt = smx_pkg::FLT_UNDER;
        else begin
          sb = $signed(fstk[ftop-1].val);
          sr = $signed(fstk[ftop-2].val);
          if (sb < 0 || sb > smx_pkg::FRAME_DEPTH || sr < 0 || sr >= smx_pkg::PROG_WORDS)
            flt = smx_pkg::FLT_ADDR;
          else begin
            ftop -= 2;
            fbase = int'(sb);
            nxt = (int'(sr) + 1) % smx_pkg::PROG_WORDS;
          end
        end
      end
      smx_pkg::OP_STO: begin
        if (!mem_ok) flt = smx_pkg::FLT_ADDR;
        else if (dtop < 1) flt = smx_pkg::FLT_UNDER;
        else begin
          dtop--;
          dmem[a] = dstk[dtop];
          mwr[a] = 1;
        end
      end
      smx_pkg::OP_RCL: begin
        if (!mem_ok) flt = smx_pkg::FLT_ADDR;
        else if (dtop >= smx_pkg::DATA_DEPTH) flt = smx_pkg::FLT_OVER;
        else begin
          dstk[dtop] = dmem[a];
          dtop++;
        end
      end
      smx_pkg::OP_END: begin
        stopped = 1;
        nxt = pc;
      end
      smx_pkg::OP_PRN: begin
        if (dtop < 1) flt = smx_pkg::FLT_UNDER;
        else begin
          dtop--;
          r.print_valid = 1'b1;
          r.print_tag = dstk[dtop].tag;
          r.print_value = dstk[dtop].val;
        end
      end
      smx_pkg::OP_STL: begin
        if (!loc_ok) flt = smx_pkg::FLT_ADDR;
        else if (dtop < 1) flt = smx_pkg::FLT_UNDER;
        else begin
          dtop--;
          fstk[loc] = dstk[dtop];
          fwr[loc] = 1;
        end
      end
      smx_pkg::OP_RCE: begin
        if (!loc_ok) flt = smx_pkg::FLT_ADDR;
        else if (dtop >= smx_pkg::DATA_DEPTH) flt = smx_pkg::FLT_OVER;
        else begin
          dstk[dtop] = fstk[loc];
          dtop++;
        end
      end
      smx_pkg::OP_ALC, smx_pkg::OP_FRE: begin
        nt = (c.func == smx_pkg::OP_ALC) ? ftop + a : ftop - a;
        if (nt > smx_pkg::FRAME_DEPTH) flt = smx_pkg::FLT_OVER;
        else if (nt < 0) flt = smx_pkg::FLT_UNDER;
        else ftop = int'(nt);
      end
      default: ;
    endcase
    if (flt == smx_pkg::FLT_OK) pc = nxt;
    r.next_address = pc[smx_pkg::PC_W-1:0];
    r.halted = stopped;
    r.fault = flt;
    return r;
  endfunction

  function automatic bit reads_unwritten(smx_pkg::cmd_t c);
    longint a, loc;
    a = c.arg_value;
    loc = a + fbase - 1;
    case (c.func)
      smx_pkg::OP_RCL: return a >= 0 && a < smx_pkg::MEM_WORDS && !mwr[a];
      smx_pkg::OP_RCE: return loc >= 0 && loc < smx_pkg::FRAME_DEPTH && !fwr[loc];
      smx_pkg::OP_RET: return ftop >= 2 && (!fwr[ftop-1] || !fwr[ftop-2]);
      default: return 0;
    endcase
  endfunction

  function automatic smx_pkg::cmd_t random_instr();
    smx_pkg::cmd_t c;
    int p;
    p = $urandom_range(0, 99);
    if (p < 30) c.func = smx_pkg::OP_PUSH;
    else begin
      c.func = smx_pkg::FUNC_W'($urandom_range(0, 31));
      if (c.func == smx_pkg::OP_END) c.func = smx_pkg::OP_DUP;
      if (c.func == smx_pkg::OP_CALL && $urandom_range(0, 1)) c.func = smx_pkg::OP_RET;
    end
    c.arg_tag = ($urandom_range(0, 3) == 0) ? 3'($urandom) : '0;
    c.arg_value = $urandom;
    p = $urandom_range(0, 19);
    case (c.func)
      smx_pkg::OP_PUSH:
        if (p < 10) c.arg_value = $signed($urandom_range(0, 6)) - 3;
      smx_pkg::OP_JMP, smx_pkg::OP_JIT, smx_pkg::OP_JIF, smx_pkg::OP_CALL:
        if (p < 18) c.arg_value = $urandom_range(0, smx_pkg::PROG_WORDS - 1);
      smx_pkg::OP_STO, smx_pkg::OP_RCL:
        if (p < 18) c.arg_value = $urandom_range(0, smx_pkg::MEM_WORDS - 1);
        else if (p < 19) c.arg_value = $signed($urandom_range(0, 8)) - 4 +
                                        (p[0] ? smx_pkg::MEM_WORDS : 0);
      smx_pkg::OP_STL, smx_pkg::OP_RCE:
        if (p < 18) c.arg_value = $urandom_range(1, ftop - fbase + 2);
      smx_pkg::OP_ALC, smx_pkg::OP_FRE:
        if (p < 16) c.arg_value = $urandom_range(0, 4);
        else if (p < 18) c.arg_value = -$signed($urandom_range(1, 3));
        else if (p < 19) c.arg_value = smx_pkg::FRAME_DEPTH + 1;
      default: ;
    endcase
    return c;
  endfunction

  task automatic add_row(logic [smx_pkg::FUNC_W-1:0] f, logic [smx_pkg::VAL_W-1:0] v,
                         logic [smx_pkg::TAG_W-1:0] t);
    step_t s;
    s.c = '{f, v, t};
    s.typed = 0;
    s.r = '0;
    program_rows.push_back(s);
  endtask

  task automatic add_known(logic [smx_pkg::FUNC_W-1:0] f, logic [smx_pkg::VAL_W-1:0] v,
                           logic [smx_pkg::TAG_W-1:0] t, smx_pkg::res_t r);
    step_t s;
    s.c = '{f, v, t};
    s.typed = 1;
    s.r = r;
    program_rows.push_back(s);
  endtask

  task automatic send_instr(smx_pkg::cmd_t c, bit typed, smx_pkg::res_t known, int idx);
    smx_pkg::res_t want;
    int gap, p;
    want = execute(c);
    pending_results.push_back(typed ? known : want);
    p = $urandom_range(0, 99);
    gap = ((idx / 150) % 3 == 0 || p < 55) ? 0 :
          (p < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
  endtask

  initial begin
    smx_pkg::cmd_t c;
    int i;
    done_sending = 0;
    dtop = 0; ftop = 0; pc = 0; fbase = 0; stopped = 0;
    for (i = 0; i < smx_pkg::FRAME_DEPTH; i++) fwr[i] = 0;
    for (i = 0; i < smx_pkg::MEM_WORDS; i++) mwr[i] = 0;

    add_known(smx_pkg::OP_POP, 0, 0, mkres(0, 0, 0, 0, smx_pkg::FLT_UNDER));
    add_row(smx_pkg::OP_PUSH, 32'h7fff_ffff, 0);
    add_row(smx_pkg::OP_PUSH, 32'h8000_0000, 7);
    add_known(smx_pkg::OP_PRN, 0, 0, mkres(3, 1, 7, 32'h8000_0000, smx_pkg::FLT_OK));
    add_known(smx_pkg::OP_PRN, 0, 0, mkres(4, 1, 0, 32'h7fff_ffff, smx_pkg::FLT_OK));
    add_row(smx_pkg::OP_PUSH, 0, 0);
    add_row(smx_pkg::OP_PUSH, 0, 0);
    add_known(smx_pkg::OP_DIV, 0, 0, mkres(6, 0, 0, 0, smx_pkg::FLT_DIV0));
    add_row(smx_pkg::OP_POP, 0, 0);
    add_row(smx_pkg::OP_POP, 0, 0);
    add_known(smx_pkg::OP_JMP, 32'hffff_ffff, 0, mkres(8, 0, 0, 0, smx_pkg::FLT_ADDR));
    add_known(smx_pkg::OP_ALC, smx_pkg::FRAME_DEPTH + 1, 0,
              mkres(8, 0, 0, 0, smx_pkg::FLT_OVER));
    add_known(smx_pkg::OP_FRE, 1, 0, mkres(8, 0, 0, 0, smx_pkg::FLT_UNDER));
    // most negative over minus one wraps
    add_row(smx_pkg::OP_PUSH, 32'h8000_0000, 0);
    add_row(smx_pkg::OP_PUSH, 32'hffff_ffff, 0);
    add_row(smx_pkg::OP_DIV, 0, 0);
    add_row(smx_pkg::OP_DUP, 0, 0);
    add_row(smx_pkg::OP_STO, smx_pkg::MEM_WORDS - 1, 0);
    add_row(smx_pkg::OP_RCL, smx_pkg::MEM_WORDS - 1, 0);
    add_row(smx_pkg::OP_PUSH, 5, 0);
    add_row(smx_pkg::OP_GT, 0, 0);
    add_row(smx_pkg::OP_JIT, smx_pkg::PROG_WORDS - 1, 0);
    add_row(smx_pkg::OP_CALL, 200, 0);
    add_row(smx_pkg::OP_ALC, 1, 0);
    add_row(smx_pkg::OP_PUSH, 9, 3);
    add_row(smx_pkg::OP_STL, 1, 0);
    add_row(smx_pkg::OP_RCE, 1, 0);
    add_row(smx_pkg::OP_MUL, 0, 0);
    add_row(smx_pkg::OP_FRE, 1, 0);
    add_row(smx_pkg::OP_RET, 0, 0);
    add_row(5'd31, 0, 0);

    @(posedge clk);
    while (rst) @(posedge clk);
    i = 0;
    foreach (program_rows[k]) begin
      send_instr(program_rows[k].c, program_rows[k].typed, program_rows[k].r, i);
      i++;
    end
    while (i < 1940) begin
      do c = random_instr(); while (reads_unwritten(c));
      send_instr(c, 0, '0, i);
      i++;
    end
    send_instr('{smx_pkg::OP_END, 0, 0}, 0, '0, 0);
    repeat (3) begin
      c = random_instr();
      send_instr(c, 0, '0, 0);
    end
    cmd_valid <= 1'b0;
    done_sending = 1;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // result side: quiet phases, random stalls and one long hold-off
  initial begin
    int p;
    cyc = 0;
    held_off = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 1500 && !held_off) begin
        held_off = 1;
        res_ready <= 1'b0;
        repeat (400) @(posedge clk);
        cyc += 400;
      end else if ((cyc / 500) % 3 == 0) begin
        res_ready <= 1'b1;
      end else begin
        p = $urandom_range(0, 99);
        if (p < 60) res_ready <= 1'b1;
        else if (p < 95) res_ready <= 1'b0;
        else begin
          res_ready <= 1'b0;
          p = $urandom_range(8, 30);
          repeat (p) @(posedge clk);
          cyc += p;
        end
      end
    end
  end

  always @(posedge clk) begin
    smx_pkg::res_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %h", res);
      end else begin
        want = pending_results.pop_front();
        if (res.next_address !== want.next_address || res.halted !== want.halted ||
            res.print_valid !== want.print_valid || res.print_tag !== want.print_tag ||
            res.print_value !== want.print_value || res.fault !== want.fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp addr %0d halt %b pv %b tag %0d val %h flt %0d",
                     want.next_address, want.halted, want.print_valid, want.print_tag,
                     want.print_value, want.fault, " / got addr %0d halt %b pv %b",
                     res.next_address, res.halted, res.print_valid,
                     " tag %0d val %h flt %0d", res.print_tag, res.print_value, res.fault);
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    wait (done_sending);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule
